FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define KVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvt assertion failed");

// next-cycle implication, checked outside reset
`define KVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvt assertion failed");

`endif

FILE: src/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int KVT_DEPTH      = 16;
  localparam int KVT_KEY_BITS   = 64;
  localparam int KVT_VALUE_BITS = 64;

  localparam int KVT_CMD_W   = 2;
  localparam int KVT_KEY_W   = 64;
  localparam int KVT_VALUE_W = 64;
  localparam int KVT_STAT_W  = 2;
  localparam int KVT_SLOT_W  = 4;

  localparam logic [KVT_CMD_W-1:0] CMD_PUT = 2'd0;
  localparam logic [KVT_CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [KVT_CMD_W-1:0] CMD_DEL = 2'd2;

  localparam logic [KVT_STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [KVT_STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [KVT_STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [KVT_STAT_W-1:0] ST_ZERO_KEY  = 2'd3;

  typedef struct packed {
    logic [KVT_CMD_W-1:0]   cmd;
    logic [KVT_KEY_W-1:0]   key;
    logic [KVT_VALUE_W-1:0] new_value;
  } kvt_in_t;

  typedef struct packed {
    logic [KVT_STAT_W-1:0]  status;
    logic                   replaced;
    logic [KVT_VALUE_W-1:0] value_out;
    logic [KVT_SLOT_W-1:0]  slot;
  } kvt_out_t;

endpackage

FILE: src/kvt_mem.sv
`timescale 1ns / 1ps

module kvt_mem #(
  parameter int WIDTH = kvt_pkg::KVT_KEY_BITS,
  parameter int DEPTH = kvt_pkg::KVT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/key_value_table_unit.sv
// flow: each transaction scans the key memory through its single read port, one
//   entry per cycle, then loads its result into the output register; a zero key
//   skips the scan; a new transaction is taken only once the last result is loaded
// reset: synchronous, active low; a clearing pass then frees every entry, and no
//   input transaction is taken until it ends
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_value_table_unit #(
  parameter int DEPTH      = kvt_pkg::KVT_DEPTH,
  parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kvt_pkg::kvt_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kvt_pkg::kvt_out_t out_data
);

  import kvt_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  localparam logic [2:0] S_CLR      = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SCAN_END = 3'd3;
  localparam logic [2:0] S_ACT      = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      addr_r, addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r;

  logic [KVT_CMD_W-1:0]  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  zero_r, zero_nxt;

  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      match_idx_r, match_idx_nxt;
  logic [VALUE_BITS-1:0] match_val_r, match_val_nxt;
  logic                  free_r, free_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  kvt_out_t              out_data_r, out_data_nxt;

  logic                  kwe, vwe;
  logic [IDX_W-1:0]      kwaddr, vwaddr;
  logic [KEY_BITS:0]     kwdata;
  logic [KEY_BITS:0]     krdata;
  logic [VALUE_BITS-1:0] vrdata;

  logic                  in_go, act_go, hit, empty;
  logic [KEY_BITS-1:0]   in_key;
  kvt_out_t              res;

  kvt_mem #(.WIDTH(KEY_BITS + 1), .DEPTH(DEPTH)) u_key_mem (
    .clk   (clk),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (kwdata),
    .raddr (addr_r),
    .rdata (krdata)
  );

  kvt_mem #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_mem (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (val_r),
    .raddr (addr_r),
    .rdata (vrdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_go     = in_valid && in_ready;
  assign in_key    = in_data.key[KEY_BITS-1:0];
  assign act_go    = (state_r == S_ACT) && (!out_valid_r || out_ready);
  assign hit       = rd_vld_r && krdata[KEY_BITS] && (krdata[KEY_BITS-1:0] == key_r);
  assign empty     = rd_vld_r && !krdata[KEY_BITS];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer and scan bookkeeping
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = (state_r == S_SCAN);
    zero_nxt      = zero_r;
    found_nxt     = found_r;
    match_idx_nxt = match_idx_r;
    match_val_nxt = match_val_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;

    if (hit && !found_r) begin
      found_nxt     = 1'b1;
      match_idx_nxt = rd_idx_r;
      match_val_nxt = vrdata;
    end
    if (empty && !free_r) begin
      free_nxt     = 1'b1;
      free_idx_nxt = rd_idx_r;
    end

    case (state_r)
      S_CLR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_go) begin
          zero_nxt  = (in_key == '0);
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          addr_nxt  = '0;
          state_nxt = (in_key == '0) ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        if (act_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result and write-back
  always_comb begin
    res.status    = ST_DONE;
    res.replaced  = 1'b0;
    res.value_out = '0;
    res.slot      = '0;
    kwe           = 1'b0;
    kwaddr        = addr_r;
    kwdata        = '0;
    vwe           = 1'b0;
    vwaddr        = match_idx_r;

    if (state_r == S_CLR) begin
      kwe = 1'b1;
    end else if (act_go) begin
      if (zero_r) begin
        res.status = ST_ZERO_KEY;
      end else begin
        case (cmd_r)
          CMD_PUT: begin
            if (found_r) begin
              res.replaced  = 1'b1;
              res.value_out = KVT_VALUE_W'(match_val_r);
              res.slot      = KVT_SLOT_W'(match_idx_r);
              vwe           = 1'b1;
            end else if (free_r) begin
              res.slot = KVT_SLOT_W'(free_idx_r);
              kwe      = 1'b1;
              kwaddr   = free_idx_r;
              kwdata   = {1'b1, key_r};
              vwe      = 1'b1;
              vwaddr   = free_idx_r;
            end else begin
              res.status = ST_FULL;
            end
          end
          CMD_GET: begin
            if (found_r) begin
              res.value_out = KVT_VALUE_W'(match_val_r);
              res.slot      = KVT_SLOT_W'(match_idx_r);
            end else begin
              res.status = ST_NOT_FOUND;
            end
          end
          CMD_DEL: begin
            if (found_r) begin
              res.slot = KVT_SLOT_W'(match_idx_r);
              kwe      = 1'b1;
              kwaddr   = match_idx_r;
              kwdata   = {1'b0, key_r};
            end else begin
              res.status = ST_NOT_FOUND;
            end
          end
          default: begin
            res.status = ST_DONE;
          end
        endcase
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (act_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      zero_r      <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      zero_r      <= zero_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= addr_r;
    match_idx_r <= match_idx_nxt;
    match_val_r <= match_val_nxt;
    free_idx_r  <= free_idx_nxt;
    out_data_r  <= out_data_nxt;
    if (in_go) begin
      cmd_r <= in_data.cmd;
      key_r <= in_key;
      val_r <= in_data.new_value[VALUE_BITS-1:0];
    end
  end

  `KVT_ASSERT_NEXT(a_act_loads_out, act_go, out_valid_r)
  `KVT_ASSERT_NEXT(a_scan_end_to_act, (state_r == S_SCAN_END), (state_r == S_ACT))
  `KVT_ASSERT_NOW(a_key_write_ctx, kwe, ((state_r == S_CLR) || act_go))
  `KVT_ASSERT_NOW(a_zero_key_no_write, (act_go && zero_r), (!kwe && !vwe))

endmodule
